// ----- hdl/assert_macros.svh -----
// Assertion macros used by the queue RTL.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- hdl/tcq_pkg.sv -----
// Types and constants of the timed command queue.
// Depends on nothing; used by the top level, the engine and the testbench.
`timescale 1ns / 1ps
package tcq_pkg;

  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_EXT    = 2'd1;
  localparam logic [1:0] REQ_CLR    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] RES_ENQ  = 2'd0;
  localparam logic [1:0] RES_EXT  = 2'd1;
  localparam logic [1:0] RES_NONE = 2'd2;
  localparam logic [1:0] RES_CLR  = 2'd3;

  localparam logic [4:0] MAX_RES = 5'd16;

  localparam logic [2:0] ADDR_ZONE_CODE = 3'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] apply_time;
    logic [7:0]  cmd_kind;
    logic [7:0]  zone_number;
    logic [63:0] cmd_payload;
    logic [63:0] now_time;
    logic [4:0]  max_out;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic        was_coalesced;
    logic [63:0] out_apply_time;
    logic [7:0]  out_cmd_kind;
    logic [7:0]  out_zone;
    logic [63:0] out_payload;
    logic        last_of_run;
    logic [4:0]  queue_count;
    logic        next_due_valid;
    logic [63:0] next_due_time;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] e_time;
    logic [7:0]  e_kind;
    logic [7:0]  e_zone;
    logic [63:0] e_data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/timed_command_queue.sv -----
// Top level of the timed command queue: register port, sequencer and result register.
// Depends on tcq_pkg and tcq_engine.
`timescale 1ns / 1ps
// Usage
// The block holds up to QUEUE_DEPTH commands sorted by apply time in one RAM
// used as a ring buffer. Requests arrive as beats on the in_ channel; every
// request (except the unused code, which is taken and dropped) yields one or
// more result beats on the out_ channel, the last flagged by last_of_run.
// An enqueue walks from the tail towards the head, moving each later entry up
// by one; on a full queue it instead searches from the head for an entry to
// coalesce with and overwrites that entry in place.
// An extract first counts the due entries, then, if entries remain, reads the
// new head, and streams the popped entries as one beat each.
// A clear goes from the idle state straight to its single result beat.
// The single RAM read port sets the pace; one request is worked on at a
// time and in_ready is high only while the sequencer is idle.
// A result register decouples the sequencer from the receiver: when out_ready
// is low the beat is held and the sequencer waits for the slot to empty.
// Reset empties the queue and sets the zone-update code to 1; RAM contents are
// left as they are, since only entries below the count are ever read.
module timed_command_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcq_pkg::out_beat_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tcq_pkg::*;

  logic [7:0] zone_code_r, zone_code_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_data_r, out_data_nxt;
  logic       res_valid, res_ready;
  out_beat_t  res_data;

  // The register is written in the access phase of an APB write.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ZONE_CODE) ? {24'd0, zone_code_r} : 32'd0;

  always_comb begin
    zone_code_nxt = zone_code_r;
    if (psel && penable && pwrite && (paddr == ADDR_ZONE_CODE)) begin
      zone_code_nxt = pwdata[7:0];
    end
  end

  tcq_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .zone_code(zone_code_r),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  // The result register takes a new beat whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_code_r <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      zone_code_r <= zone_code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

// ----- hdl/tcq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module tcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/tcq_engine.sv -----
// Sequencer of the queue: insert, coalesce, extract and clear over the entry RAM.
// Depends on tcq_pkg, tcq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcq_engine #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcq_pkg::in_beat_t  in_data,
  input  logic [7:0]         zone_code,
  output logic               res_valid,
  input  logic               res_ready,
  output tcq_pkg::out_beat_t res_data
);
  import tcq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((AW > CW) ? AW : CW) + 1;
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_INS_RD   = 12'b000000000010,
    S_INS_CHK  = 12'b000000000100,
    S_CO_RD    = 12'b000000001000,
    S_CO_CHK   = 12'b000000010000,
    S_CNT_RD   = 12'b000000100000,
    S_CNT_CHK  = 12'b000001000000,
    S_HEAD_RD  = 12'b000010000000,
    S_HEAD_CAP = 12'b000100000000,
    S_EMIT_ONE = 12'b001000000000,
    S_EMIT_RD  = 12'b010000000000,
    S_EMIT_WR  = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  in_beat_t        req_r, req_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   old_head_r, old_head_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   nout_r, nout_nxt;
  logic            acc_r, acc_nxt;
  logic            coal_r, coal_nxt;
  logic            stop_r, stop_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [63:0]     head_time_r, head_time_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent, new_ent;
  logic [4:0]         lim;
  logic               more;
  logic               match;

  // Ring-buffer position of logical offset off from base.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  tcq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);
  assign new_ent = '{e_time: req_r.apply_time, e_kind: req_r.cmd_kind,
                     e_zone: req_r.zone_number, e_data: req_r.cmd_payload};
  assign lim = (req_r.max_out > MAX_RES) ? MAX_RES : req_r.max_out;
  assign more = !stop_r && (PW'(idx_r) < PW'(lim)) && (idx_r < count_r);
  assign match = (rd_ent.e_kind == req_r.cmd_kind) &&
                 ((req_r.cmd_kind != zone_code) || (rd_ent.e_zone == req_r.zone_number));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    old_head_nxt  = old_head_r;
    idx_nxt       = idx_r;
    nout_nxt      = nout_r;
    acc_nxt       = acc_r;
    coal_nxt      = coal_r;
    stop_nxt      = stop_r;
    kind_nxt      = kind_r;
    head_time_nxt = head_time_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = new_ent;
    ram_re        = 1'b0;
    ram_raddr     = head_r;
    res_valid     = 1'b0;
    res_data      = '0;
    res_data.queue_count    = 5'(count_r);
    res_data.next_due_valid = (count_r != '0);
    res_data.next_due_time  = (count_r != '0) ? head_time_r : 64'd0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          acc_nxt  = 1'b0;
          coal_nxt = 1'b0;
          stop_nxt = 1'b0;
          kind_nxt = RES_ENQ;
          case (in_data.req_type)
            REQ_ENQ: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                idx_nxt   = '0;
                state_nxt = S_CO_RD;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            REQ_EXT: begin
              idx_nxt   = '0;
              state_nxt = S_CNT_RD;
            end
            REQ_CLR: begin
              count_nxt = '0;
              head_nxt  = '0;
              kind_nxt  = RES_CLR;
              state_nxt = S_EMIT_ONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = head_r;
          count_nxt = count_r + CW'(1);
          acc_nxt   = 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r - CW'(1));
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r);
        if (req_r.apply_time < rd_ent.e_time) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          acc_nxt   = 1'b1;
          state_nxt = S_HEAD_RD;
        end
      end
      S_CO_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_HEAD_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r);
          state_nxt = S_CO_CHK;
        end
      end
      S_CO_CHK: begin
        if (match) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, idx_r);
          acc_nxt   = 1'b1;
          coal_nxt  = 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_CO_RD;
        end
      end
      S_CNT_RD: begin
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r);
          state_nxt = S_CNT_CHK;
        end else begin
          nout_nxt     = idx_r;
          old_head_nxt = head_r;
          head_nxt     = phys(head_r, idx_r);
          count_nxt    = count_r - idx_r;
          idx_nxt      = '0;
          kind_nxt     = (idx_r == '0) ? RES_NONE : RES_EXT;
          if (count_r != idx_r) begin
            state_nxt = S_HEAD_RD;
          end else if (idx_r == '0) begin
            state_nxt = S_EMIT_ONE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_CNT_CHK: begin
        if (rd_ent.e_time <= req_r.now_time) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          stop_nxt = 1'b1;
        end
        state_nxt = S_CNT_RD;
      end
      S_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        state_nxt = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        head_time_nxt = rd_ent.e_time;
        state_nxt     = (kind_r == RES_EXT) ? S_EMIT_RD : S_EMIT_ONE;
      end
      S_EMIT_ONE: begin
        res_valid              = 1'b1;
        res_data.result_kind   = kind_r;
        res_data.accepted      = acc_r;
        res_data.was_coalesced = coal_r;
        res_data.last_of_run   = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = phys(old_head_r, idx_r);
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        res_valid               = 1'b1;
        res_data.result_kind    = RES_EXT;
        res_data.out_apply_time = rd_ent.e_time;
        res_data.out_cmd_kind   = rd_ent.e_kind;
        res_data.out_zone       = rd_ent.e_zone;
        res_data.out_payload    = rd_ent.e_data;
        res_data.last_of_run    = (idx_r + CW'(1) == nout_r);
        if (res_ready) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = (idx_r + CW'(1) == nout_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    old_head_r  <= old_head_nxt;
    idx_r       <= idx_nxt;
    nout_r      <= nout_nxt;
    acc_r       <= acc_nxt;
    coal_r      <= coal_nxt;
    stop_r      <= stop_nxt;
    kind_r      <= kind_nxt;
    head_time_r <= head_time_nxt;
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `ASSERT_ALWAYS(a_head_bound, SW'(head_r) < SW'(QUEUE_DEPTH), "head pointer out of range")
  `ASSERT_ALWAYS(a_no_rw_clash, !(ram_we && ram_re) || (ram_waddr != ram_raddr), "RAM read and write hit one entry")
  `ASSERT_NEXT(a_emit_hold, (state_r == S_EMIT_WR) && !res_ready, (state_r == S_EMIT_WR) && $stable(ram_rdata), "stalled extracted entry changed")
endmodule

// ----- test/timed_command_queue_tb.sv -----
// Self-checking testbench of the timed command queue: directed, coalescing and random tests.
// Depends on tcq_pkg and timed_command_queue; predicts every result beat in the bench itself.
`timescale 1ns / 1ps
module timed_command_queue_tb;
  import tcq_pkg::*;

  localparam int DEPTH = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  timed_command_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents and of the zone-update register.
  entry_t shadow_q[DEPTH];
  int shadow_count;
  logic [7:0] shadow_zone_code;

  // Result beats that the shadow queue says must still come out, oldest first.
  out_beat_t pending_results[$];
  int mismatches = 0;
  bit quiet_mode = 1'b0;   // when set, neither side inserts gaps or stalls
  logic [63:0] time_base;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A request beat with every field random.
  function automatic in_beat_t rand_beat();
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return in_beat_t'(raw[$bits(in_beat_t)-1:0]);
  endfunction

  // Work out the result beats of one accepted request and queue them up.
  function automatic void predict_results(in_beat_t b);
    out_beat_t res[MAX_RES];
    int n;
    int pos;
    int lim;
    bit hit;
    entry_t e;
    n = 0;
    e = '{e_time: b.apply_time, e_kind: b.cmd_kind, e_zone: b.zone_number,
          e_data: b.cmd_payload};
    case (b.req_type)
      REQ_ENQ: begin
        res[0] = '0;
        res[0].result_kind = RES_ENQ;
        if (shadow_count >= DEPTH) begin
          // Full queue: overwrite the first entry of the same type (and zone, for the zone-update type) in place.
          hit = 1'b0;
          for (int j = 0; j < DEPTH && !hit; j++) begin
            if (shadow_q[j].e_kind == b.cmd_kind &&
                (b.cmd_kind != shadow_zone_code || shadow_q[j].e_zone == b.zone_number)) begin
              shadow_q[j] = e;
              hit = 1'b1;
            end
          end
          res[0].accepted = hit;
          res[0].was_coalesced = hit;
        end else begin
          // Insert after every entry that is due at the same time or earlier.
          pos = 0;
          while (pos < shadow_count && !(b.apply_time < shadow_q[pos].e_time)) pos++;
          for (int j = shadow_count; j > pos; j--) shadow_q[j] = shadow_q[j-1];
          shadow_q[pos] = e;
          shadow_count++;
          res[0].accepted = 1'b1;
        end
        n = 1;
      end
      REQ_EXT: begin
        lim = (b.max_out > MAX_RES) ? MAX_RES : b.max_out;
        while (n < lim && shadow_count > 0 && shadow_q[0].e_time <= b.now_time) begin
          res[n] = '0;
          res[n].result_kind = RES_EXT;
          res[n].out_apply_time = shadow_q[0].e_time;
          res[n].out_cmd_kind = shadow_q[0].e_kind;
          res[n].out_zone = shadow_q[0].e_zone;
          res[n].out_payload = shadow_q[0].e_data;
          n++;
          shadow_count--;
          for (int j = 0; j < shadow_count; j++) shadow_q[j] = shadow_q[j+1];
        end
        if (n == 0) begin
          res[0] = '0;
          res[0].result_kind = RES_NONE;
          n = 1;
        end
      end
      REQ_CLR: begin
        shadow_count = 0;
        res[0] = '0;
        res[0].result_kind = RES_CLR;
        n = 1;
      end
      default: n = 0;   // the unused code is taken and produces nothing
    endcase
    // Count and head time describe the queue after the whole request.
    for (int i = 0; i < n; i++) begin
      res[i].last_of_run = (i == n - 1);
      res[i].queue_count = shadow_count[4:0];
      res[i].next_due_valid = (shadow_count > 0);
      res[i].next_due_time = (shadow_count > 0) ? shadow_q[0].e_time : 64'd0;
      pending_results.push_back(res[i]);
    end
  endfunction

  // Drive one request beat, wait for it to be taken, then perhaps leave a gap.
  // With no gap valid simply stays high into the next beat.
  task automatic send_request(in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    predict_results(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_beat_t enq_beat(logic [63:0] t, logic [7:0] k, logic [7:0] z,
                                        logic [63:0] d);
    in_beat_t b;
    b = rand_beat();
    b.req_type = REQ_ENQ;
    b.apply_time = t;
    b.cmd_kind = k;
    b.zone_number = z;
    b.cmd_payload = d;
    return b;
  endfunction

  function automatic in_beat_t ext_beat(logic [63:0] now, logic [4:0] lim);
    in_beat_t b;
    b = rand_beat();
    b.req_type = REQ_EXT;
    b.now_time = now;
    b.max_out = lim;
    return b;
  endfunction

  function automatic in_beat_t other_beat(logic [1:0] code);
    in_beat_t b;
    b = rand_beat();
    b.req_type = code;
    return b;
  endfunction

  // Wait for every predicted beat, then give a request without results time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; the write lands on the access edge.
  task automatic write_zone_code(logic [7:0] code);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ZONE_CODE;
    pwdata <= {16'($urandom_range(0, 16'hffff)), 8'h00, code};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_zone_code = code;
    @(posedge clk);
  endtask

  // Receiver: random stalls on out_ready, with the same gap profile as the sender.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Checker: every result beat taken is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind ||
            out_data.accepted !== want.accepted ||
            out_data.was_coalesced !== want.was_coalesced ||
            out_data.out_apply_time !== want.out_apply_time ||
            out_data.out_cmd_kind !== want.out_cmd_kind ||
            out_data.out_zone !== want.out_zone ||
            out_data.out_payload !== want.out_payload ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.queue_count !== want.queue_count ||
            out_data.next_due_valid !== want.next_due_valid ||
            out_data.next_due_time !== want.next_due_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p, got %p", $realtime, want, out_data);
        end
      end
    end
  end

  // Extremes of the fields, each request code, the capped limit and an empty queue.
  task automatic test_directed();
    send_request(ext_beat(64'd0, 5'd4));                  // empty queue: a none result
    send_request(enq_beat('1, 8'hff, 8'hff, '1));
    send_request(enq_beat('0, 8'h00, 8'h00, '0));
    send_request(enq_beat(64'd5, 8'h01, 8'h80, 64'h5555_aaaa_5555_aaaa));
    send_request(enq_beat(64'd5, 8'h02, 8'h7f, 64'haaaa_5555_aaaa_5555));
    send_request(other_beat(REQ_UNUSED));                 // unused code: no result
    send_request(ext_beat(64'd10, 5'd0));                 // zero limit
    send_request(ext_beat(64'd4, 5'd1));
    send_request(ext_beat('1, 5'd31));                    // limit above the cap
    send_request(enq_beat(64'd100, 8'h10, 8'h01, rand64()));
    send_request(ext_beat(64'd99, 5'd16));                // nothing due yet
    send_request(other_beat(REQ_CLR));
    send_request(ext_beat('1, 5'd16));
  endtask

  // Fill the queue, then hit every branch of the full-queue overwrite.
  task automatic test_full_queue();
    send_request(other_beat(REQ_CLR));
    for (int i = 0; i < DEPTH; i++)
      send_request(enq_beat(64'd1000 - 64'(i * 7), 8'(i % 4), 8'(i), rand64()));
    send_request(enq_beat(64'd3, 8'h02, 8'h55, rand64()));              // same type
    send_request(enq_beat(64'd4, shadow_zone_code, 8'h99, rand64()));   // zone differs
    send_request(enq_beat(64'd4, shadow_zone_code, 8'h05, rand64()));   // zone matches if the code is 1
    send_request(enq_beat(64'd6, 8'hee, 8'h00, rand64()));              // no match
    send_request(ext_beat(64'd2000, 5'd31));
  endtask

  // Random mix. Times cluster round a drifting base so that extracts find due
  // entries and the queue often fills; types come from a small set so that the
  // full-queue overwrite is hit. Now and then a field takes fully random bits.
  task automatic test_random(int count);
    int r;
    logic [63:0] t;
    logic [7:0] k;
    logic [7:0] z;
    logic [4:0] lim;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t = ($urandom_range(0, 9) == 0) ? rand64() : time_base + $urandom_range(0, 200);
        r = $urandom_range(0, 9);
        k = (r < 3) ? shadow_zone_code : (r < 9) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        z = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        send_request(enq_beat(t, k, z, rand64()));
      end else if (r < 90) begin
        lim = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 5));
        t = ($urandom_range(0, 19) == 0) ? rand64() : time_base + $urandom_range(0, 250);
        send_request(ext_beat(t, lim));
        time_base = time_base + $urandom_range(0, 40);
      end else if (r < 95) begin
        send_request(other_beat(REQ_CLR));
      end else begin
        send_request(other_beat(REQ_UNUSED));
      end
    end
  endtask

  initial begin
    shadow_count = 0;
    shadow_zone_code = 8'd1;
    time_base = 64'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_random(80);
    wait_idle();

    write_zone_code(8'd0);
    test_full_queue();
    quiet_mode = 1'b1;          // a stretch with no gaps on either side
    test_random(40);
    quiet_mode = 1'b0;
    wait_idle();

    write_zone_code(8'd255);
    test_full_queue();
    test_random(70);
    wait_idle();

    write_zone_code(8'($urandom_range(2, 4)));
    test_random(80);
    wait_idle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, sized well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
